// File: hw/rtl/rbs_pkg.sv
// Shared types, widths, register indexes and helper functions for the
// ray/box slab intersection unit. No dependencies.
package rbs_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS   = 14;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int DIST_W  = 31;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int NUM_W   = MAG_W + DIR_FRAC_BITS;
    localparam int Q_W     = COORD_W;
    localparam int REM_W   = DIR_W;
    localparam int PROD_W  = DIR_W + COORD_W;
    localparam int SHIFT_W = PROD_W - DIR_FRAC_BITS;
    localparam int SUM_W   = SHIFT_W + 1;

    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] AX_X = 2'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // Tolerances: the tie window is 1e-4 in Q16.16 and the parallel test
    // is 1e-6 in Q2.14, both reduced to integer magnitude limits.
    localparam int TIE_LIMIT = ((1 << COORD_FRAC_BITS) - 1) / 10000;
    localparam int PAR_LIMIT = ((1 << DIR_FRAC_BITS) - 1) / 1000000;
    localparam int NZ_LIMIT  = (1 << DIR_FRAC_BITS) / 1000000;
    localparam int DIR_ONE   = 1 << DIR_FRAC_BITS;

    // Divider pipeline shape.
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_ITERS          = Q_W / DIV_BITS_PER_STAGE;
    localparam int DIV_LAT            = DIV_ITERS + 2;

    // Front-to-back queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam dir_t   DIR_MAX   = {1'b0, {(DIR_W-1){1'b1}}};
    localparam dir_t   DIR_MIN   = {1'b1, {(DIR_W-1){1'b0}}};
    localparam dir_t   NORM_POS  = DIR_W'(DIR_ONE);
    localparam dir_t   NORM_NEG  = DIR_W'(-DIR_ONE);

    typedef struct packed {
        coord_t [NUM_AXES-1:0] lo;
        coord_t [NUM_AXES-1:0] hi;
    } box_t;

    // One classified ray as it sits in the queue.
    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        dir_t   [NUM_AXES-1:0] dir;
        dist_t                 max_dist;
        diff_t  [NUM_AXES-1:0] dlo;
        diff_t  [NUM_AXES-1:0] dhi;
        logic                  in_box;
        logic                  par_miss;
    } front_item_t;

    function automatic logic [DIR_W-1:0] dir_mag(input dir_t d);
        return d[DIR_W-1] ? (DIR_W'(~d) + DIR_W'(1)) : DIR_W'(d);
    endfunction

    function automatic logic dir_is_parallel(input dir_t d);
        return dir_mag(d) <= DIR_W'(PAR_LIMIT);
    endfunction

    function automatic logic dir_is_nonzero(input dir_t d);
        return dir_mag(d) > DIR_W'(NZ_LIMIT);
    endfunction

endpackage

// File: hw/rtl/rbs_channels.sv
// Handshake channel interfaces for the ray input and the hit result.
// Depends on rbs_pkg.
interface rbs_ray_if import rbs_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
    dist_t  max_dist;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z, output max_dist,
                    input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, input max_dist,
                  output ready);
endinterface

interface rbs_hit_if import rbs_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   hit;
    dist_t  impact_dist;
    coord_t impact_x;
    coord_t impact_y;
    coord_t impact_z;
    dir_t   normal_x;
    dir_t   normal_y;
    dir_t   normal_z;

    modport source (output valid, output hit, output impact_dist, output impact_x,
                    output impact_y, output impact_z, output normal_x, output normal_y,
                    output normal_z, input ready);
    modport sink (input valid, input hit, input impact_dist, input impact_x,
                  input impact_y, input impact_z, input normal_x, input normal_y,
                  input normal_z, output ready);
endinterface

// File: hw/rtl/ray_box_slab_intersection_unit.sv
// Top level of the ray/box slab intersection unit: box registers, front end,
// queue and back-end pipeline. Depends on rbs_pkg, rbs_channels, rbs_front,
// rbs_queue and rbs_back.
//
//   Channel  Direction  Handshake             Transaction
//   ray      in         ray.valid/ray.ready   origin, direction, max distance
//   result   out        result.valid/ready    hit, distance, point, normal
//   cfg      in         cfg_wr_en             box bound at cfg_index
//
// A ray enters every cycle while the queue has room; one result leaves per
// cycle while the sink takes it. With no stall, a ray passes the queue, the
// slab dividers (setup, eight four-bit iteration stages, saturation), three
// slab-clip stages, the product stage and the result register. The dividers
// set the depth.
// Reset clears the box registers to zero and empties the queue and pipeline.
// A stalled result freezes the back end; the four-entry queue keeps taking
// rays until it fills, so input ready depends only on the queue count.
module ray_box_slab_intersection_unit import rbs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    rbs_ray_if.sink              ray,
    rbs_hit_if.source            result
);

    box_t box_reg, box_next;

    // Box bounds are plain registers; the user must write them only while the
    // unit is idle (the block does not enforce this), so no shadowing is needed.
    always_comb
    begin
        box_next = box_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_X: box_next.lo[0] = cfg_wdata;
                CFG_MIN_Y: box_next.lo[1] = cfg_wdata;
                CFG_MIN_Z: box_next.lo[2] = cfg_wdata;
                CFG_MAX_X: box_next.hi[0] = cfg_wdata;
                CFG_MAX_Y: box_next.hi[1] = cfg_wdata;
                CFG_MAX_Z: box_next.hi[2] = cfg_wdata;
                default:   box_next       = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    // The front end classifies each ray in the cycle it is accepted and
    // writes it straight into the queue.
    logic        q_full;
    logic        q_push;
    front_item_t q_push_item;
    logic        q_pop;
    logic        q_head_valid;
    front_item_t q_head_item;

    rbs_front u_front (
        .ray    (ray),
        .box    (box_reg),
        .q_full (q_full),
        .push   (q_push),
        .item   (q_push_item)
    );

    rbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // The back end pulls from the queue whenever its pipeline advances.
    rbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .pop        (q_pop),
        .result     (result)
    );

endmodule

// File: hw/rtl/rbs_front.sv
// Front end: takes rays, computes the slab offsets and classifies each ray
// as inside the box, missed by a parallel axis, or needing the slab test.
// Depends on rbs_pkg and rbs_channels.
module rbs_front import rbs_pkg::*; (
    rbs_ray_if.sink     ray,
    input  box_t        box,
    input  logic        q_full,
    output logic        push,
    output front_item_t item
);

    logic [NUM_AXES-1:0] in_slab;
    logic [NUM_AXES-1:0] parallel;

    assign ray.ready = !q_full;
    assign push      = ray.valid && !q_full;

    always_comb
    begin
        item.origin[0] = ray.origin_x;
        item.origin[1] = ray.origin_y;
        item.origin[2] = ray.origin_z;
        item.dir[0]    = ray.dir_x;
        item.dir[1]    = ray.dir_y;
        item.dir[2]    = ray.dir_z;
        item.max_dist  = ray.max_dist;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            item.dlo[k] = DIFF_W'($signed(box.lo[k])) - DIFF_W'($signed(item.origin[k]));
            item.dhi[k] = DIFF_W'($signed(box.hi[k])) - DIFF_W'($signed(item.origin[k]));
            // The origin sits in the slab when lo - o <= 0 and hi - o >= 0.
            in_slab[k]  = item.dlo[k][DIFF_W-1] || (item.dlo[k] == '0);
            in_slab[k]  = in_slab[k] && !item.dhi[k][DIFF_W-1];
            parallel[k] = dir_is_parallel(item.dir[k]);
        end
        item.in_box   = &in_slab;
        item.par_miss = |(parallel & ~in_slab);
    end

endmodule

// File: hw/rtl/rbs_queue.sv
// Short flop-based queue between the front end and the back-end pipeline.
// Depends on rbs_pkg.
module rbs_queue import rbs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output front_item_t head_item
);

    front_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[QPTR_W-1:0] == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

// File: hw/rtl/rbs_div.sv
// Pipelined signed divider for slab distances: (diff << DIR_FRAC_BITS) / dir,
// truncated toward zero and saturated to 32 bits. Depends on rbs_pkg.
module rbs_div import rbs_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  diff_t  diff,
    input  dir_t   divisor,
    output coord_t quot
);

    logic [REM_W-1:0] mag_d_reg [DIV_ITERS+1];
    logic [REM_W-1:0] rem_reg   [DIV_ITERS+1];
    logic [Q_W-1:0]   work_reg  [DIV_ITERS+1];
    logic             neg_reg   [DIV_ITERS+1];
    logic             over_reg  [DIV_ITERS+1];
    coord_t           quot_reg, quot_next;

    logic [MAG_W-1:0] mag_n;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] mag_d;

    always_comb
    begin
        mag_n = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        num   = {mag_n, {DIR_FRAC_BITS{1'b0}}};
        mag_d = dir_mag(divisor);
        if (mag_d == '0)
        begin
            mag_d = REM_W'(1);
        end
    end

    // Setup stage: a quotient of 2^32 or more is flagged and saturated later.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_d_reg[0] <= mag_d;
            rem_reg[0]   <= REM_W'(num >> Q_W);
            work_reg[0]  <= num[Q_W-1:0];
            neg_reg[0]   <= diff[DIFF_W-1] ^ divisor[DIR_W-1];
            over_reg[0]  <= (num >> Q_W) >= NUM_W'(mag_d);
        end
    end

    for (genvar g = 1; g <= DIV_ITERS; g++)
    begin : g_iter
        logic [REM_W-1:0] rem_next;
        logic [Q_W-1:0]   work_next;

        // Restoring division, a few quotient bits per stage; the quotient
        // shifts into the low end of the dividend word.
        always_comb
        begin
            logic [REM_W:0] trial;
            rem_next  = rem_reg[g-1];
            work_next = work_reg[g-1];
            for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
            begin
                trial     = {rem_next, work_next[Q_W-1]};
                work_next = {work_next[Q_W-2:0], 1'b0};
                if (trial >= {1'b0, mag_d_reg[g-1]})
                begin
                    rem_next     = REM_W'(trial - {1'b0, mag_d_reg[g-1]});
                    work_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = REM_W'(trial);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_d_reg[g] <= mag_d_reg[g-1];
                rem_reg[g]   <= rem_next;
                work_reg[g]  <= work_next;
                neg_reg[g]   <= neg_reg[g-1];
                over_reg[g]  <= over_reg[g-1];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[DIV_ITERS])
        begin
            if (over_reg[DIV_ITERS] || (work_reg[DIV_ITERS] > Q_W'(COORD_MIN)))
            begin
                quot_next = COORD_MIN;
            end
            else
            begin
                quot_next = COORD_W'(~work_reg[DIV_ITERS] + Q_W'(1));
            end
        end
        else
        begin
            if (over_reg[DIV_ITERS] || work_reg[DIV_ITERS][Q_W-1])
            begin
                quot_next = COORD_MAX;
            end
            else
            begin
                quot_next = COORD_W'(work_reg[DIV_ITERS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// File: hw/rtl/rbs_back.sv
// Back-end pipeline: six slab dividers, three slab-clip stages, the normal
// choice and impact products, then the result register. Depends on rbs_pkg,
// rbs_channels and rbs_div.
module rbs_back import rbs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  front_item_t head_item,
    output logic        pop,
    rbs_hit_if.source   result
);

    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        dir_t   [NUM_AXES-1:0] dir;
        dist_t                 max_dist;
        logic                  in_box;
        logic                  par_miss;
    } side_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        dir_t   [NUM_AXES-1:0] dir;
        logic                  in_box;
        logic                  miss;
        coord_t                tmin;
        coord_t                tmax;
        coord_t [NUM_AXES-1:0] te;
        coord_t [NUM_AXES-1:0] t_lo;
        coord_t [NUM_AXES-1:0] t_hi;
    } slab_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] origin;
        logic                  in_box;
        logic                  miss;
        coord_t                tmin;
        prod_t  [NUM_AXES-1:0] prod;
        dir_t   [NUM_AXES-1:0] normal;
        dir_t   [NUM_AXES-1:0] inside_normal;
    } mul_t;

    typedef struct packed {
        logic                  hit;
        dist_t                 impact_dist;
        coord_t [NUM_AXES-1:0] impact;
        dir_t   [NUM_AXES-1:0] normal;
    } out_t;

    logic adv;
    logic out_valid_reg;

    // The whole pipeline advances together unless a finished result waits.
    assign adv = !out_valid_reg || result.ready;
    assign pop = adv && head_valid;

    // Slab distance dividers, one per bound per axis.
    coord_t t_lo [NUM_AXES];
    coord_t t_hi [NUM_AXES];

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_div
        rbs_div u_div_lo (
            .clk     (clk),
            .en      (adv),
            .diff    (head_item.dlo[g]),
            .divisor (head_item.dir[g]),
            .quot    (t_lo[g])
        );
        rbs_div u_div_hi (
            .clk     (clk),
            .en      (adv),
            .diff    (head_item.dhi[g]),
            .divisor (head_item.dir[g]),
            .quot    (t_hi[g])
        );
    end

    // Side data travels next to the dividers.
    side_t              side_reg [DIV_LAT];
    logic [DIV_LAT-1:0] side_vld_reg;
    side_t              side_in;

    always_comb
    begin
        side_in.origin   = head_item.origin;
        side_in.dir      = head_item.dir;
        side_in.max_dist = head_item.max_dist;
        side_in.in_box   = head_item.in_box;
        side_in.par_miss = head_item.par_miss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_vld_reg <= '0;
        end
        else if (adv)
        begin
            side_vld_reg <= {side_vld_reg[DIV_LAT-2:0], head_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // One axis of the slab clip: order the two ends and, for a non-parallel axis,
    // test against the running interval, then narrow it and note the axis entry distance.
    function automatic slab_t slab_step(input slab_t s, input logic [AXIS_W-1:0] k);
        slab_t  r;
        coord_t a;
        coord_t b;
        coord_t near_t;
        coord_t far_t;
        r = s;
        a = s.t_lo[k];
        b = s.t_hi[k];
        if ($signed(a) > $signed(b))
        begin
            near_t = b;
            far_t  = a;
        end
        else
        begin
            near_t = a;
            far_t  = b;
        end
        if (!dir_is_parallel(s.dir[k]))
        begin
            if (($signed(far_t) < $signed(s.tmin)) || ($signed(near_t) > $signed(s.tmax)))
            begin
                r.miss = 1'b1;
            end
            if ($signed(near_t) > $signed(s.tmin))
            begin
                r.tmin  = near_t;
                r.te[k] = near_t;
            end
            if ($signed(far_t) < $signed(s.tmax))
            begin
                r.tmax = far_t;
            end
        end
        return r;
    endfunction

    slab_t                slab_init;
    slab_t                slab_reg [NUM_AXES];
    logic [NUM_AXES-1:0]  slab_vld_reg;

    always_comb
    begin
        slab_init.origin = side_reg[DIV_LAT-1].origin;
        slab_init.dir    = side_reg[DIV_LAT-1].dir;
        slab_init.in_box = side_reg[DIV_LAT-1].in_box;
        slab_init.miss   = side_reg[DIV_LAT-1].par_miss;
        slab_init.tmin   = '0;
        slab_init.tmax   = COORD_W'(side_reg[DIV_LAT-1].max_dist);
        slab_init.te     = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            slab_init.t_lo[k] = t_lo[k];
            slab_init.t_hi[k] = t_hi[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slab_vld_reg <= '0;
        end
        else if (adv)
        begin
            slab_vld_reg <= {slab_vld_reg[NUM_AXES-2:0], side_vld_reg[DIV_LAT-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slab_reg[0] <= slab_step(slab_init, AX_X);
            slab_reg[1] <= slab_step(slab_reg[0], AX_Y);
            slab_reg[2] <= slab_step(slab_reg[1], AX_Z);
        end
    end

    // Normal choice and impact products.
    mul_t mul_reg, mul_next;
    logic mul_vld_reg;

    always_comb
    begin
        logic [NUM_AXES-1:0] tie;
        diff_t               dd;
        mul_next.origin = slab_reg[2].origin;
        mul_next.in_box = slab_reg[2].in_box;
        mul_next.miss   = slab_reg[2].miss;
        mul_next.tmin   = slab_reg[2].tmin;
        mul_next.normal = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            dd = DIFF_W'($signed(slab_reg[2].te[k])) - DIFF_W'($signed(slab_reg[2].tmin));
            tie[k] = (dd <= DIFF_W'(TIE_LIMIT)) && (dd >= -DIFF_W'(TIE_LIMIT))
                     && dir_is_nonzero(slab_reg[2].dir[k]);
            mul_next.prod[k] = PROD_W'($signed(slab_reg[2].dir[k]))
                               * PROD_W'($signed(slab_reg[2].tmin));
            // Minus the direction, with the most negative code clamped.
            if (slab_reg[2].dir[k] == DIR_MIN)
            begin
                mul_next.inside_normal[k] = DIR_MAX;
            end
            else
            begin
                mul_next.inside_normal[k] = -slab_reg[2].dir[k];
            end
        end
        priority if (tie[0])
        begin
            mul_next.normal[0] = ($signed(slab_reg[2].dir[0]) > 0) ? NORM_NEG : NORM_POS;
        end
        else if (tie[1])
        begin
            mul_next.normal[1] = ($signed(slab_reg[2].dir[1]) > 0) ? NORM_NEG : NORM_POS;
        end
        else
        begin
            mul_next.normal[2] = ($signed(slab_reg[2].dir[2]) > 0) ? NORM_NEG : NORM_POS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_vld_reg <= slab_vld_reg[NUM_AXES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_reg <= mul_next;
        end
    end

    // Impact point, result selection and the output register.
    out_t out_reg, out_next;

    always_comb
    begin
        prod_t                pr;
        logic signed [SHIFT_W-1:0] sh;
        logic signed [SUM_W-1:0]   sm;
        coord_t [NUM_AXES-1:0] point;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            pr = mul_reg.prod[k];
            // Division by the direction scale rounds toward zero.
            if (pr[PROD_W-1])
            begin
                pr = pr + PROD_W'(DIR_ONE - 1);
            end
            sh = SHIFT_W'(pr >>> DIR_FRAC_BITS);
            sm = SUM_W'($signed(mul_reg.origin[k])) + SUM_W'(sh);
            if ((sm[SUM_W-1:COORD_W-1] == '0) || (sm[SUM_W-1:COORD_W-1] == '1))
            begin
                point[k] = COORD_W'(sm);
            end
            else
            begin
                point[k] = sm[SUM_W-1] ? COORD_MIN : COORD_MAX;
            end
        end
        priority if (mul_reg.in_box)
        begin
            out_next.hit         = 1'b1;
            out_next.impact_dist = '0;
            out_next.impact      = mul_reg.origin;
            out_next.normal      = mul_reg.inside_normal;
        end
        else if (mul_reg.miss)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.hit         = 1'b1;
            out_next.impact_dist = mul_reg.tmin[DIST_W-1:0];
            out_next.impact      = point;
            out_next.normal      = mul_reg.normal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hit         = out_reg.hit;
    assign result.impact_dist = out_reg.impact_dist;
    assign result.impact_x    = out_reg.impact[0];
    assign result.impact_y    = out_reg.impact[1];
    assign result.impact_z    = out_reg.impact[2];
    assign result.normal_x    = out_reg.normal[0];
    assign result.normal_y    = out_reg.normal[1];
    assign result.normal_z    = out_reg.normal[2];

    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        slab_vld_reg[NUM_AXES-1] && !slab_reg[2].miss
            |-> $signed(slab_reg[2].tmin) <= $signed(slab_reg[2].tmax))
        else $error("slab interval inverted without a miss");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit
            |-> result.impact_dist == '0 && result.impact_x == '0 &&
                result.impact_y == '0 && result.impact_z == '0 &&
                result.normal_x == '0 && result.normal_y == '0 &&
                result.normal_z == '0)
        else $error("miss transaction carries nonzero fields");

    a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit && result.impact_dist != '0
            |-> $countones({result.normal_x != '0, result.normal_y != '0,
                            result.normal_z != '0}) == 1)
        else $error("slab hit must have exactly one normal axis");

endmodule
